// File: rtl/core/scsa_pkg.sv
// Package for the slab size-class allocator: widths, status codes,
// size-class tables and the item type passed from front to back.
// No dependencies.
package scsa_pkg;

    localparam int MAX_CLASSES     = 32;
    localparam int NUM_CLASSES_DEF = 16;
    localparam int BATCH_PAGES     = 32;
    localparam int PAGE_NUM_LIMIT  = 8192;
    localparam int QUEUE_DEPTH     = 2;

    localparam int REQ_W    = 32;
    localparam int CFG_W    = 13;
    localparam int STATUS_W = 2;
    localparam int PAGE_W   = 13;
    localparam int TAKEN_W  = 14;
    localparam int POOL_W   = 6;
    localparam int SLOT_W   = 12;
    localparam int SIZE_W   = 20;
    localparam int OFFS_W   = 20;
    localparam int CLS_W    = 5;

    localparam logic [CFG_W-1:0] LIMIT_MIB_RESET = CFG_W'(64);

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_TOO_LARGE = 2'd1,
        STS_NO_MEM    = 2'd2
    } t_status;

    // slot size per class: 512, then floor(5*s/4)
    localparam logic [SIZE_W-1:0] CLASS_BYTES [MAX_CLASSES] = '{
        20'd512,    20'd640,    20'd800,    20'd1000,
        20'd1250,   20'd1562,   20'd1952,   20'd2440,
        20'd3050,   20'd3812,   20'd4765,   20'd5956,
        20'd7445,   20'd9306,   20'd11632,  20'd14540,
        20'd18175,  20'd22718,  20'd28397,  20'd35496,
        20'd44370,  20'd55462,  20'd69327,  20'd86658,
        20'd108322, 20'd135402, 20'd169252, 20'd211565,
        20'd264456, 20'd330570, 20'd413212, 20'd516515
    };

    // slots per 1 MiB page for each class
    localparam logic [SLOT_W-1:0] CLASS_SLOTS [MAX_CLASSES] = '{
        12'd2048, 12'd1638, 12'd1310, 12'd1048,
        12'd838,  12'd671,  12'd537,  12'd429,
        12'd343,  12'd275,  12'd220,  12'd176,
        12'd140,  12'd112,  12'd90,   12'd72,
        12'd57,   12'd46,   12'd36,   12'd29,
        12'd23,   12'd18,   12'd15,   12'd12,
        12'd9,    12'd7,    12'd6,    12'd4,
        12'd3,    12'd3,    12'd2,    12'd2
    };

    typedef struct packed {
        logic              too_large;
        logic [CLS_W-1:0]  cls;
        logic [SIZE_W-1:0] size;
    } t_req_item;

endpackage

// File: rtl/core/scsa_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on scsa_pkg.
interface scsa_req_if import scsa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] request_bytes;

    modport source(output valid, output request_bytes, input ready);
    modport sink(input valid, input request_bytes, output ready);
endinterface

interface scsa_res_if import scsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_number;
    logic [OFFS_W-1:0]   byte_offset;

    modport source(output valid, output status, output page_number, output byte_offset,
                   input ready);
    modport sink(input valid, input status, input page_number, input byte_offset,
                 output ready);
endinterface

// File: rtl/core/scsa_front.sv
// Front end: accepts request items and maps each to its size class.
// Depends on scsa_pkg and scsa_req_if.
module scsa_front import scsa_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    scsa_req_if.sink   i_req,
    input  logic       i_full,
    output logic       o_push,
    output t_req_item  o_item
);

    logic             found;
    logic [CLS_W-1:0] cls;

    // smallest class that holds the request
    always_comb begin
        found = 1'b0;
        cls   = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if ({{(REQ_W-SIZE_W){1'b0}}, CLASS_BYTES[c]} >= i_req.request_bytes) begin
                found = 1'b1;
                cls   = CLS_W'(c);
            end
        end
    end

    assign i_req.ready      = !i_full;
    assign o_push           = i_req.valid && !i_full;
    assign o_item.too_large = !found;
    assign o_item.cls       = cls;
    assign o_item.size      = CLASS_BYTES[cls];

endmodule

// File: rtl/core/scsa_queue.sv
// Small flop queue of classified items between front and back.
// Depends on scsa_pkg.
module scsa_queue import scsa_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_req_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output t_req_item o_item,
    output logic      o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_req_item        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: rtl/core/scsa_back.sv
// Back end: per-class page/slot state, page pool, bump allocation, result register.
// Depends on scsa_pkg and scsa_res_if.
module scsa_back import scsa_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_req_item        i_item,
    input  logic             i_empty,
    output logic             o_pop,
    scsa_res_if.source       o_res
);

    localparam int CIDX_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    typedef enum logic [1:0] {
        BK_READ   = 2'b01,
        BK_COMMIT = 2'b10
    } t_back_state;

    t_back_state         r_state;
    logic [CFG_W-1:0]    r_limit_mib;
    logic [PAGE_W-1:0]   r_cls_page [NUM_CLASSES];
    logic [SLOT_W-1:0]   r_cls_used [NUM_CLASSES];
    logic [POOL_W-1:0]   r_pool_free, n_pool_free;
    logic [TAKEN_W-1:0]  r_pages_taken, n_pages_taken;

    t_req_item           r_item;
    logic                r_full;
    logic [SLOT_W-1:0]   r_slot;
    logic [PAGE_W-1:0]   r_page;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [PAGE_W-1:0]   r_out_page;
    logic [OFFS_W-1:0]   r_out_offset;

    logic [CIDX_W-1:0]   rd_idx, wr_idx;
    logic                rd_full;
    logic                out_free;
    logic                commit;
    logic                do_alloc;
    t_status             status;
    logic [PAGE_W-1:0]   page;
    logic [SLOT_W+SIZE_W-1:0] prod;

    assign rd_idx   = i_item.cls[CIDX_W-1:0];
    assign wr_idx   = r_item.cls[CIDX_W-1:0];
    assign rd_full  = r_cls_used[rd_idx] >= CLASS_SLOTS[i_item.cls];
    assign out_free = !r_out_valid || o_res.ready;
    assign o_pop    = (r_state == BK_READ) && !i_empty;
    assign commit   = (r_state == BK_COMMIT) && out_free;
    assign prod     = r_slot * r_item.size;

    // too large, bump, else pool page; fresh batch when empty and within budget
    always_comb begin
        n_pool_free   = r_pool_free;
        n_pages_taken = r_pages_taken;
        page          = r_page;
        status        = STS_OK;
        do_alloc      = 1'b0;
        if (r_item.too_large) begin
            status = STS_TOO_LARGE;
        end else if (!r_full) begin
            do_alloc = 1'b1;
        end else if (r_pool_free != '0) begin
            n_pool_free = r_pool_free - 1'b1;
            page        = PAGE_W'(r_pages_taken - TAKEN_W'(BATCH_PAGES)
                                  + TAKEN_W'(n_pool_free));
            do_alloc    = 1'b1;
        end else if ((r_pages_taken >= {1'b0, r_limit_mib}) ||
                     ({1'b0, r_pages_taken} + (TAKEN_W+1)'(BATCH_PAGES)
                      > (TAKEN_W+1)'(PAGE_NUM_LIMIT))) begin
            status = STS_NO_MEM;
        end else begin
            n_pages_taken = r_pages_taken + TAKEN_W'(BATCH_PAGES);
            n_pool_free   = POOL_W'(BATCH_PAGES - 1);
            page          = PAGE_W'(r_pages_taken + TAKEN_W'(BATCH_PAGES - 1));
            do_alloc      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_READ;
            r_limit_mib   <= LIMIT_MIB_RESET;
            r_pool_free   <= POOL_W'(BATCH_PAGES - NUM_CLASSES);
            r_pages_taken <= TAKEN_W'(BATCH_PAGES);
            r_out_valid   <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_cls_page[c] <= PAGE_W'(BATCH_PAGES - 1 - c);
                r_cls_used[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit_mib <= i_cfg_wdata;
            end
            case (r_state)
                BK_READ: begin
                    if (!i_empty) begin
                        r_state <= BK_COMMIT;
                    end
                end
                BK_COMMIT: begin
                    if (out_free) begin
                        r_state <= BK_READ;
                    end
                end
                default: begin
                    r_state <= BK_READ;
                end
            endcase
            if (commit) begin
                r_out_valid <= 1'b1;
                if (do_alloc) begin
                    r_cls_page[wr_idx] <= page;
                    r_cls_used[wr_idx] <= r_slot + 1'b1;
                    r_pool_free        <= n_pool_free;
                    r_pages_taken      <= n_pages_taken;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
            r_full <= rd_full;
            r_slot <= rd_full ? '0 : r_cls_used[rd_idx];
            r_page <= r_cls_page[rd_idx];
        end
        if (commit) begin
            r_out_status <= status;
            r_out_page   <= (status == STS_OK) ? page : '0;
            r_out_offset <= (status == STS_OK) ? prod[OFFS_W-1:0] : '0;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.page_number = r_out_page;
    assign o_res.byte_offset = r_out_offset;

`ifndef SYNTHESIS
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pool_free <= POOL_W'(BATCH_PAGES))
        else $error("pool count above batch size");

    a_taken_batches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pages_taken % TAKEN_W'(BATCH_PAGES)) == '0) &&
        (r_pages_taken <= TAKEN_W'(PAGE_NUM_LIMIT)))
        else $error("pages taken not a whole number of batches in range");

    a_commit_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_state == BK_READ) && r_out_valid)
        else $error("commit did not load result and return to read");
`endif

endmodule

// File: rtl/core/slab_size_class_allocator.sv
// Slab size-class allocator top level: front classifier, item queue, back allocator.
// An accepted request is written to the queue, read into the back-end item register and
// committed to the result register. The back end reads then commits one item at a time on
// the per-class page state. The front keeps accepting while the queue has room.
// Reset: synchronous, active low; loads the start-up class pages and pool directly,
// no clearing pass.
module slab_size_class_allocator import scsa_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    scsa_req_if.sink         i_req,
    scsa_res_if.source       o_res,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_req_item front_item;
    t_req_item queue_item;
    logic      push;
    logic      full;
    logic      pop;
    logic      empty;

    scsa_front #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_item (front_item)
    );

    scsa_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (empty)
    );

    scsa_back #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (queue_item),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule

// File: dv/slab_size_class_allocator_tb.sv
// Testbench for slab_size_class_allocator: directed table, then constrained-by-hand random
// requests, each result checked against its table entry or a local allocator predictor.
// Depends on scsa_pkg, scsa_req_if / scsa_res_if and the allocator RTL.
module slab_size_class_allocator_tb;
    import scsa_pkg::*;

    localparam int N_CLASSES  = NUM_CLASSES_DEF;
    localparam int PAGE_SIZE  = 1048576;
    localparam int DRAIN_GAP  = 6;
    localparam int RAND_ITEMS = 165;
    localparam int NOMEM_RUNS = 8;

    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] page;
        logic [OFFS_W-1:0] offset;
    } t_alloc_result;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             fixed;
        t_alloc_result    res;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{32'd0,          1'b1, '{STS_OK,        13'd31, 20'd0}},
        '{32'd512,        1'b1, '{STS_OK,        13'd31, 20'd512}},
        '{32'd1,          1'b1, '{STS_OK,        13'd31, 20'd1024}},
        '{32'd513,        1'b1, '{STS_OK,        13'd30, 20'd0}},
        '{32'd640,        1'b1, '{STS_OK,        13'd30, 20'd640}},
        '{32'd14540,      1'b1, '{STS_OK,        13'd16, 20'd0}},
        '{32'd14541,      1'b1, '{STS_TOO_LARGE, 13'd0,  20'd0}},
        '{32'hFFFF_FFFF,  1'b1, '{STS_TOO_LARGE, 13'd0,  20'd0}},
        '{32'h8000_0000,  1'b1, '{STS_TOO_LARGE, 13'd0,  20'd0}},
        '{32'd14000,      1'b1, '{STS_OK,        13'd16, 20'd14540}},
        '{32'd641,        1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd800,        1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd801,        1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd1000,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd1250,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd1562,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd1952,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd2440,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd3050,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd3812,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd4765,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd5956,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd7445,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd9306,       1'b0, '{STS_OK,        13'd0,  20'd0}},
        '{32'd11632,      1'b0, '{STS_OK,        13'd0,  20'd0}}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    scsa_req_if req_if();
    scsa_res_if res_if();

    slab_size_class_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // predictor state
    int unsigned       class_bytes [N_CLASSES];
    int unsigned       class_slots [N_CLASSES];
    logic [PAGE_W-1:0] class_page  [N_CLASSES];
    int unsigned       class_used  [N_CLASSES];
    int unsigned       pool_free;
    int unsigned       taken_total;
    int unsigned       limit_mib;

    t_alloc_result alloc_expected_q [$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int requests_sent;
    int results_seen;
    int too_large_seen;
    int nomem_seen;
    int nomem_predicted;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit grab_page(input int cls);
        if (pool_free == 0) begin
            if (taken_total >= limit_mib) return 1'b0;
            if (taken_total + BATCH_PAGES > PAGE_NUM_LIMIT) return 1'b0;
            taken_total += BATCH_PAGES;
            pool_free = BATCH_PAGES;
        end
        pool_free--;
        class_page[cls] = PAGE_W'(taken_total - BATCH_PAGES + pool_free);
        class_used[cls] = 0;
        return 1'b1;
    endfunction

    function automatic void reset_allocator_state();
        int unsigned s;
        s = 512;
        for (int c = 0; c < N_CLASSES; c++) begin
            class_bytes[c] = s;
            class_slots[c] = PAGE_SIZE / s;
            s = (s * 5) / 4;
        end
        limit_mib   = LIMIT_MIB_RESET;
        pool_free   = 0;
        taken_total = 0;
        for (int c = 0; c < N_CLASSES; c++) begin
            if (!grab_page(c)) begin
                class_page[c] = '0;
                class_used[c] = class_slots[c];
            end
        end
    endfunction

    function automatic t_alloc_result predict_alloc(input logic [REQ_W-1:0] req);
        t_alloc_result r;
        int cls;
        r   = '{STS_OK, '0, '0};
        cls = -1;
        for (int c = 0; c < N_CLASSES; c++) begin
            if (cls < 0 && class_bytes[c] >= req) cls = c;
        end
        if (cls < 0) begin
            r.status = STS_TOO_LARGE;
            return r;
        end
        if (class_used[cls] >= class_slots[cls] && !grab_page(cls)) begin
            r.status = STS_NO_MEM;
            return r;
        end
        r.page   = class_page[cls];
        r.offset = OFFS_W'(class_used[cls] * class_bytes[cls]);
        class_used[cls]++;
        return r;
    endfunction

    function automatic logic [REQ_W-1:0] random_request();
        int k;
        int c;
        int unsigned lo;
        k = $urandom_range(99);
        c = $urandom_range(N_CLASSES - 1);
        lo = (c == 0) ? 0 : class_bytes[c-1] + 1;
        if (k < 8) begin
            case ($urandom_range(3))
                0: return REQ_W'(class_bytes[c]);
                1: return REQ_W'(class_bytes[c] + 1);
                2: return '0;
                default: return REQ_W'(lo);
            endcase
        end else if (k < 20) begin
            if ($urandom_range(1)) return $urandom();
            return REQ_W'($urandom_range(class_bytes[N_CLASSES-1] + 1, 20000));
        end else if (k < 55) begin
            return REQ_W'($urandom_range(class_bytes[N_CLASSES-2] + 1,
                                         class_bytes[N_CLASSES-1]));
        end
        return REQ_W'($urandom_range(lo, class_bytes[c]));
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic fixed,
                                input t_alloc_result fixed_res);
        t_alloc_result pred;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.request_bytes <= req;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pred = predict_alloc(req);
        if (pred.status == STS_NO_MEM) nomem_predicted++;
        alloc_expected_q.push_back(fixed ? fixed_res : pred);
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (alloc_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        limit_mib = value;
    endtask

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (res_if.status == STS_TOO_LARGE) too_large_seen++;
            if (res_if.status == STS_NO_MEM) nomem_seen++;
            if (alloc_expected_q.size() == 0) begin
                $error("unexpected result: status %0d page %0d offset %0d",
                       res_if.status, res_if.page_number, res_if.byte_offset);
                fail_count++;
            end else begin
                exp_res = alloc_expected_q.pop_front();
                if (res_if.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, res_if.status);
                    fail_count++;
                end
                if (res_if.page_number !== exp_res.page) begin
                    $error("page_number: expected %0d, got %0d",
                           exp_res.page, res_if.page_number);
                    fail_count++;
                end
                if (res_if.byte_offset !== exp_res.offset) begin
                    $error("byte_offset: expected %0d, got %0d",
                           exp_res.offset, res_if.byte_offset);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int unsigned    phase_limit [4];
        int             phase_send  [4];
        int             phase_recv  [4];
        t_alloc_result  no_res;
        phase_limit = '{4096, 8191, 0, 64};
        phase_send  = '{0, 56, 0, 29};
        phase_recv  = '{0, 0, 56, 29};
        no_res      = '{STS_OK, '0, '0};

        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_if.valid         = 1'b0;
        req_if.request_bytes = '0;
        res_if.ready         = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        fail_count           = 0;
        requests_sent        = 0;
        results_seen         = 0;
        too_large_seen       = 0;
        nomem_seen           = 0;
        nomem_predicted      = 0;
        reset_allocator_state();

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(DIR_TABLE[i].req, DIR_TABLE[i].fixed, DIR_TABLE[i].res);

        // minimum budget: drain the pool with mostly largest-class requests until out of memory
        wait_drained();
        write_limit(CFG_W'(1));
        while (nomem_predicted < NOMEM_RUNS) begin
            if ($urandom_range(99) < 85)
                send_request(REQ_W'($urandom_range(class_bytes[N_CLASSES-2] + 1,
                                                   class_bytes[N_CLASSES-1])), 1'b0, no_res);
            else
                send_request(random_request(), 1'b0, no_res);
        end

        for (int p = 0; p < 4; p++) begin
            wait_drained();
            write_limit(CFG_W'(phase_limit[p]));
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (int i = 0; i < RAND_ITEMS; i++) begin
                if (p == 1 && i == RAND_ITEMS / 2) wait_drained();
                send_request(random_request(), 1'b0, no_res);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (alloc_expected_q.size() != 0) begin
            $error("%0d results never arrived", alloc_expected_q.size());
            fail_count++;
        end

        $display("Sent %0d requests over five budget settings and four idle patterns.",
                 requests_sent);
        $display("Checked %0d results: %0d too large, %0d out of memory.",
                 results_seen, too_large_seen, nomem_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
